>>> rtl/core/sdes_block_cipher_defines.svh
// Assertion macros shared by the S-DES checker.
// Depends on nothing; the including scope must provide clk_i and rst_ni.
`ifndef SDES_BLOCK_CIPHER_DEFINES_SVH
`define SDES_BLOCK_CIPHER_DEFINES_SVH

// Property that must hold at every clock edge outside of reset.
`define SDES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent matches.
`define SDES_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/core/sdes_pkg.sv
// Package for the S-DES block cipher: pipeline types, S-box tables and
// the permutation and round functions. Depends on nothing.
`timescale 1ns / 1ps

package sdes_pkg;

  // Control bits that travel with each block down the pipeline.
  typedef struct packed {
    logic valid;
    logic decrypt;
  } stage_ctl_t;

  // The two 8-bit round subkeys.
  typedef struct packed {
    logic [7:0] k1;
    logic [7:0] k2;
  } subkeys_t;

  typedef logic [1:0] sbox_t [16];

  // S-boxes indexed by {row, column}; row is outer bits, column inner bits.
  localparam sbox_t SBOX0 = '{
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd3, 2'd2, 2'd1, 2'd0,
    2'd0, 2'd2, 2'd1, 2'd3,
    2'd3, 2'd1, 2'd3, 2'd2
  };
  localparam sbox_t SBOX1 = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd0,
    2'd2, 2'd1, 2'd0, 2'd3
  };

  // Initial permutation.
  function automatic logic [7:0] perm_ip(input logic [7:0] v);
    return {v[6], v[2], v[5], v[7], v[4], v[0], v[3], v[1]};
  endfunction

  // Inverse of the initial permutation.
  function automatic logic [7:0] perm_ip_inv(input logic [7:0] v);
    return {v[4], v[7], v[5], v[3], v[1], v[6], v[0], v[2]};
  endfunction

  // Expansion of the right half to eight bits.
  function automatic logic [7:0] perm_ep(input logic [3:0] r);
    return {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]};
  endfunction

  // Permutation of the S-box outputs.
  function automatic logic [3:0] perm_p4(input logic [3:0] s);
    return {s[2], s[0], s[1], s[3]};
  endfunction

  // Key permutation on the full 10-bit key.
  function automatic logic [9:0] perm_p10(input logic [9:0] k);
    return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
  endfunction

  // Compression of the shifted key to a subkey.
  function automatic logic [7:0] perm_p8(input logic [9:0] v);
    return {v[4], v[7], v[3], v[6], v[2], v[5], v[0], v[1]};
  endfunction

  // One Feistel round: the left half absorbs the mixed right half.
  function automatic logic [7:0] round_fk(input logic [7:0] x, input logic [7:0] k);
    logic [7:0] e;
    logic [3:0] s;
    e = perm_ep(x[3:0]) ^ k;
    s = {SBOX0[{e[7], e[4], e[6:5]}], SBOX1[{e[3], e[0], e[2:1]}]};
    return {x[7:4] ^ perm_p4(s), x[3:0]};
  endfunction

endpackage

>>> rtl/core/sdes_key_sched.sv
// Key register and subkey schedule for the S-DES cipher.
// Depends on sdes_pkg for the subkey type and the key permutations.
`timescale 1ns / 1ps

module sdes_key_sched (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [9:0]         key_i,
  output sdes_pkg::subkeys_t subkeys_o
);

  logic [9:0]         p10;
  logic [4:0]         lh1, rh1, lh3, rh3;
  sdes_pkg::subkeys_t subkeys_d, subkeys_q;

  // Subkeys derived from the key on its way in: rotate by one for K1,
  // by three in total for K2.
  always_comb begin
    p10          = sdes_pkg::perm_p10(key_i);
    lh1          = {p10[8:5], p10[9]};
    rh1          = {p10[3:0], p10[4]};
    lh3          = {p10[6:5], p10[9:7]};
    rh3          = {p10[1:0], p10[4:2]};
    subkeys_d.k1 = sdes_pkg::perm_p8({lh1, rh1});
    subkeys_d.k2 = sdes_pkg::perm_p8({lh3, rh3});
  end

  // A zero key gives zero subkeys, which is the reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subkeys_q <= '0;
    end else if (wr_en_i) begin
      subkeys_q <= subkeys_d;
    end
  end

  assign subkeys_o = subkeys_q;

endmodule

>>> rtl/core/sdes_round.sv
// One registered Feistel round stage of the S-DES pipeline.
// Depends on sdes_pkg for the control type and the round function.
`timescale 1ns / 1ps

module sdes_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  sdes_pkg::stage_ctl_t ctl_i,
  input  logic [7:0]           blk_i,
  input  logic [7:0]           key_i,
  output sdes_pkg::stage_ctl_t ctl_o,
  output logic [7:0]           blk_o
);

  sdes_pkg::stage_ctl_t ctl_q;
  logic [7:0]           blk_d, blk_q;

  assign blk_d = sdes_pkg::round_fk(blk_i, key_i);

  // Control bits are reset; the block value only moves with them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      blk_q <= blk_d;
    end
  end

  assign ctl_o = ctl_q;
  assign blk_o = blk_q;

endmodule

>>> rtl/core/sdes_block_cipher.sv
// S-DES block cipher, three register stages: initial permutation, round one, round two.
// Each accepted block passes the stage-zero register, then round one and round two.
// Throughput: one block per cycle; the whole pipeline holds while the output is stalled.
// Reset: all stage valid bits clear and the key returns to zero.
// Depends on sdes_pkg, sdes_key_sched and sdes_round.
`timescale 1ns / 1ps

module sdes_block_cipher (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write channel.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [9:0] cfg_data_i,
  // Input stream.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_in
  input  logic       s_axis_tuser,   // [0] req_type
  // Output stream.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [7:0] data_out
);

  logic                 adv;
  sdes_pkg::subkeys_t   subkeys;
  sdes_pkg::stage_ctl_t s0_ctl_d, s0_ctl_q, r1_ctl, r2_ctl;
  logic [7:0]           s0_blk_d, s0_blk_q;
  logic [7:0]           r1_blk, r1_swap, r2_blk;
  logic [7:0]           r1_key, r2_key;

  // The pipeline moves whenever the output register is empty or drained.
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  sdes_key_sched u_key_sched (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .key_i     (cfg_data_i),
    .subkeys_o (subkeys)
  );

  // Stage zero: initial permutation of the incoming block.
  always_comb begin
    s0_ctl_d.valid   = s_axis_tvalid;
    s0_ctl_d.decrypt = s_axis_tuser;
    s0_blk_d         = sdes_pkg::perm_ip(s_axis_tdata);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ctl_q <= '0;
    end else if (adv) begin
      s0_ctl_q <= s0_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_blk_q <= s0_blk_d;
    end
  end

  // Decryption runs the subkeys in reverse order.
  assign r1_key = s0_ctl_q.decrypt ? subkeys.k2 : subkeys.k1;
  assign r2_key = r1_ctl.decrypt   ? subkeys.k1 : subkeys.k2;

  sdes_round u_round1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ctl_i  (s0_ctl_q),
    .blk_i  (s0_blk_q),
    .key_i  (r1_key),
    .ctl_o  (r1_ctl),
    .blk_o  (r1_blk)
  );

  // Halves swap between the two rounds.
  assign r1_swap = {r1_blk[3:0], r1_blk[7:4]};

  sdes_round u_round2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ctl_i  (r1_ctl),
    .blk_i  (r1_swap),
    .key_i  (r2_key),
    .ctl_o  (r2_ctl),
    .blk_o  (r2_blk)
  );

  // The second round register is the output register.
  assign m_axis_tvalid = r2_ctl.valid;
  assign m_axis_tdata  = sdes_pkg::perm_ip_inv(r2_blk);

endmodule

>>> rtl/core/sdes_checker.sv
// Port-level checks for the S-DES block cipher, bound to the top level.
// Depends on sdes_block_cipher_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`include "sdes_block_cipher_defines.svh"

module sdes_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [9:0] cfg_data_i,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // A stalled result keeps its transaction on the bus.
  `SDES_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

  // The input side is open exactly when the output register can move.
  `SDES_ASSERT(a_ready_link, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output state")

  // With the output always ready, an accepted block must come out of the pipeline registers.
  `SDES_ASSERT_NEXT(a_latency, s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready ##1 m_axis_tready, m_axis_tvalid, "result missing after pipeline latency")

  // Input transactions carry known values.
  `SDES_ASSERT(a_in_known, !s_axis_tvalid || !$isunknown({s_axis_tuser, s_axis_tdata}), "unknown input")

  // Key writes carry a known value.
  `SDES_ASSERT(a_cfg_known, !(cfg_valid_i && cfg_ready_o) || !$isunknown(cfg_data_i), "unknown key")

endmodule

bind sdes_block_cipher sdes_checker u_sdes_checker (.*);

>>> verif/sdes_block_cipher_chk.sv
// Checker for the S-DES block cipher: watches the key, input and output channels,
// predicts each output block and compares it. Depends on nothing but its ports.
`timescale 1ns / 1ps

module sdes_block_cipher_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_in
  input  logic        s_axis_tuser_i,   // [0] req_type
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // [7:0] data_out
  output int unsigned err_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  // Bit selections, 1-based from the most significant bit; unused slots are zero.
  typedef int unsigned pos_list_t [10];
  localparam pos_list_t KEY_P10    = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
  localparam pos_list_t KEY_P8     = '{6, 3, 7, 4, 8, 5, 10, 9, 0, 0};
  localparam pos_list_t BLK_IP     = '{2, 6, 3, 1, 4, 8, 5, 7, 0, 0};
  localparam pos_list_t BLK_IP_INV = '{4, 1, 3, 5, 7, 2, 8, 6, 0, 0};
  localparam pos_list_t HALF_EP    = '{4, 1, 2, 3, 2, 3, 4, 1, 0, 0};
  localparam pos_list_t MIX_P4     = '{2, 4, 3, 1, 0, 0, 0, 0, 0, 0};

  // Substitution boxes as [row][column].
  typedef logic [1:0] sub_box_t [4][4];
  localparam sub_box_t SUB_BOX0 = '{
    '{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1, 2'd3}, '{2'd3, 2'd1, 2'd3, 2'd2}
  };
  localparam sub_box_t SUB_BOX1 = '{
    '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd0}, '{2'd2, 2'd1, 2'd0, 2'd3}
  };

  logic [9:0] cipher_key_q;
  logic [7:0] expected_blocks [$];

  // Gathers out_w bits of an in_w-bit value in table order, first pick ends up on top.
  function automatic logic [9:0] pick_bits(input logic [9:0] v, input int unsigned in_w,
                                           input pos_list_t tab, input int unsigned out_w);
    logic [9:0] r;
    r = '0;
    for (int unsigned i = 0; i < out_w; i++) begin
      r = {r[8:0], v[in_w - tab[i]]};
    end
    return r;
  endfunction

  function automatic logic [4:0] rotl5(input logic [4:0] h, input int unsigned n);
    return (h << n) | (h >> (5 - n));
  endfunction

  // Row comes from the outer bits of the nibble, column from the inner two.
  function automatic logic [1:0] sub_lookup(input sub_box_t box, input logic [3:0] nib);
    return box[{nib[3], nib[0]}][nib[2:1]];
  endfunction

  // One Feistel round: the left half absorbs the mixed right half.
  function automatic logic [7:0] feistel_round(input logic [7:0] x, input logic [7:0] k);
    logic [7:0] e;
    logic [3:0] s;
    logic [3:0] p;
    e = 8'(pick_bits({6'b0, x[3:0]}, 4, HALF_EP, 8)) ^ k;
    s = {sub_lookup(SUB_BOX0, e[7:4]), sub_lookup(SUB_BOX1, e[3:0])};
    p = 4'(pick_bits({6'b0, s}, 4, MIX_P4, 4));
    return {x[7:4] ^ p, x[3:0]};
  endfunction

  // Full cipher on one block: derive both subkeys, then two rounds around a half swap.
  function automatic logic [7:0] sdes_predict(input logic [9:0] key, input logic decrypt,
                                              input logic [7:0] blk);
    logic [9:0] p;
    logic [4:0] lh;
    logic [4:0] rh;
    logic [7:0] k1;
    logic [7:0] k2;
    logic [7:0] t;
    p  = pick_bits(key, 10, KEY_P10, 10);
    lh = rotl5(p[9:5], 1);
    rh = rotl5(p[4:0], 1);
    k1 = 8'(pick_bits({lh, rh}, 10, KEY_P8, 8));
    lh = rotl5(lh, 2);
    rh = rotl5(rh, 2);
    k2 = 8'(pick_bits({lh, rh}, 10, KEY_P8, 8));
    t  = 8'(pick_bits({2'b0, blk}, 8, BLK_IP, 8));
    t  = feistel_round(t, decrypt ? k2 : k1);
    t  = {t[3:0], t[7:4]};
    t  = feistel_round(t, decrypt ? k1 : k2);
    t  = 8'(pick_bits({2'b0, t}, 8, BLK_IP_INV, 8));
    return t;
  endfunction

  // Track the key, queue a prediction per input transaction, check each output one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_key_q <= '0;
      expected_blocks.delete();
      err_count_o <= 0;
      checked_o   <= 0;
      pending_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        cipher_key_q <= cfg_data_i;
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected output block: expected none, actual %02h",
                   $realtime, m_axis_tdata_i);
          err_count_o <= err_count_o + 1;
        end else begin
          if (expected_blocks[0] !== m_axis_tdata_i) begin
            $display("%0t: data_out mismatch: expected %02h, actual %02h",
                     $realtime, expected_blocks[0], m_axis_tdata_i);
            err_count_o <= err_count_o + 1;
          end
          void'(expected_blocks.pop_front());
          checked_o <= checked_o + 1;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_blocks.push_back(sdes_predict(cipher_key_q, s_axis_tuser_i, s_axis_tdata_i));
      end
      pending_o <= expected_blocks.size();
    end
  end

endmodule

>>> verif/sdes_block_cipher_tb.sv
// Testbench top for the S-DES block cipher: clock, reset, key writes, block stimulus
// and output back-pressure. Depends on sdes_block_cipher and sdes_block_cipher_chk.
`timescale 1ns / 1ps

module sdes_block_cipher_tb;

  typedef enum logic {REQ_ENCRYPT = 1'b0, REQ_DECRYPT = 1'b1} req_kind_e;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [9:0] cfg_data_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] data_in
  logic       s_axis_tuser;   // [0] req_type
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b1;
  logic [7:0] m_axis_tdata;   // [7:0] data_out

  int unsigned err_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycle_count = 0;
  int unsigned enc_count;
  int unsigned dec_count;
  int unsigned key_settings;

  // Receiver back-pressure state.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  sdes_block_cipher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sdes_block_cipher_chk checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .err_count_o     (err_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish, %0d blocks still outstanding", $realtime, pending);
      $display("sdes_block_cipher_tb: done, errors");
      $finish;
    end
  end

  // Output back-pressure: switch between a few stall styles every so often.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        m_axis_tready <= (stall_tick % 3) != 0;
      end
    endcase
  end

  // Present one block and hold it until the input transaction completes.
  task automatic push_block(input req_kind_e kind, input logic [7:0] blk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= blk;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (kind == REQ_DECRYPT) dec_count++;
    else enc_count++;
  endtask

  // Random blocks in bursts with random gaps, some bursts back to back.
  task automatic stream_blocks(input int unsigned count);
    int unsigned burst;
    int unsigned gap;
    logic [7:0] blk;
    while (count > 0) begin
      burst = $urandom_range(1, 32);
      if (burst > count) burst = count;
      count -= burst;
      repeat (burst) begin
        blk = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0) blk = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        push_block(req_kind_e'($urandom_range(0, 1)), blk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Wait until every predicted block has come out and the pipeline has drained.
  task automatic wait_idle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_key(input logic [9:0] key);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= key;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    key_settings++;
  endtask

  initial begin
    logic [7:0] corner_blocks [6];
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_ENCRYPT;
    enc_count     = 0;
    dec_count     = 0;
    key_settings  = 1;
    corner_blocks = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Key left at its reset value: corner blocks in both directions, then a random stream.
    foreach (corner_blocks[i]) begin
      push_block(REQ_ENCRYPT, corner_blocks[i]);
      push_block(REQ_DECRYPT, corner_blocks[i]);
    end
    stream_blocks(150);

    // All-ones key.
    write_key(10'h3FF);
    push_block(REQ_ENCRYPT, 8'h00);
    push_block(REQ_DECRYPT, 8'h00);
    push_block(REQ_ENCRYPT, 8'hFF);
    push_block(REQ_DECRYPT, 8'hFF);
    stream_blocks(150);

    // All-zero key written explicitly.
    write_key(10'h000);
    stream_blocks(100);

    // The textbook key with its well-known block pair.
    write_key(10'b1010000010);
    push_block(REQ_ENCRYPT, 8'b10010111);
    push_block(REQ_DECRYPT, 8'b00111000);
    stream_blocks(100);

    // Random keys.
    repeat (8) begin
      write_key(10'($urandom_range(0, 1023)));
      stream_blocks(150);
    end

    wait_idle();
    $display("Covered %0d blocks (%0d encrypt, %0d decrypt) under %0d key settings,",
             enc_count + dec_count, enc_count, dec_count, key_settings);
    $display("with random gaps on the input and stalls on the output; %0d blocks checked.",
             checked);
    if (err_count == 0) begin
      $display("sdes_block_cipher_tb: done, clean");
    end else begin
      $display("sdes_block_cipher_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> sdes_block_cipher.f
+incdir+rtl/core
rtl/core/sdes_pkg.sv
rtl/core/sdes_key_sched.sv
rtl/core/sdes_round.sv
rtl/core/sdes_block_cipher.sv
rtl/core/sdes_checker.sv
verif/sdes_block_cipher_chk.sv
verif/sdes_block_cipher_tb.sv
